### src/mpu_pkg.sv
// mpu_pkg: sizes, fixed-point constants and payload types of the MLEM projection update block.
// No dependencies; imported by the top-level module.
package mpu_pkg;
    localparam int VOXELS       = 4096;
    localparam int MAX_SEGMENTS = 256;
    localparam int VOX_AW       = $clog2(VOXELS);
    localparam int SEG_AW       = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 2);

    localparam logic [31:0] INIT_RESET = 32'd6553600;  // 100.0 in Q16.16
    localparam logic [47:0] ONE_Q16    = 48'd65536;

    localparam logic [1:0] ACT_SEGMENT = 2'd0;
    localparam logic [1:0] ACT_APPLY   = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;
    localparam logic [1:0] ACT_RELOAD  = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [11:0] voxel_index;
        logic [23:0] segment_weight;
        logic [31:0] measured_projection;
        logic        last_segment;
    } t_in;

    typedef struct packed {
        logic [47:0] forward_sum;
        logic [31:0] voxel_value;
        logic        done_res;
        logic        ray_overflow;
    } t_out;
endpackage

### src/mpu_ram.sv
// mpu_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module mpu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### src/mlem_projection_update.sv
// mlem_projection_update: MLEM forward/back projection and image update sequencer.
// Depends on mpu_pkg and mpu_ram (image, ratio, sensitivity and segment buffer memories).
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in  (t_in)
//  out     | output    | o_out_valid / i_out_ready  | o_out (t_out)
//  cfg     | input     | i_cfg_we, no wait          | i_cfg_data (initial_value)
//
// Segment: image read, shared 32x24 multiplier, saturating add. Last segment: plus the
// 80-step bit-serial divider, setup, hand-over and a back-projection pass per buffered
// segment. Apply: voxels with zero sensitivity only get ratio and sensitivity cleared, the
// others take two partial products and the 80-step divider; a hand-over follows at the end.
// After reset a clearing pass initializes the image, ratio and sensitivity RAMs; no input then.
// A waiting result does not block the next transaction; the sequencer stalls only to hand over.
module mlem_projection_update (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  mpu_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output mpu_pkg::t_out o_out,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_data
);
    import mpu_pkg::*;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_SEG_RD, S_SEG_MUL, S_SEG_ACC, S_RAY_END, S_DIV,
        S_BP_RB, S_BP_E, S_BP_M, S_BP_W, S_AP_RD, S_AP_CK, S_AP_M1, S_AP_M2,
        S_AP_M3, S_AP_WR, S_RD_WAIT, S_RL, S_OUT
    } t_state;

    t_state             r_state;
    logic [31:0]        r_init;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   r_bptr;
    logic [47:0]        r_sum;
    logic [VOX_AW-1:0]  r_addr;
    logic [23:0]        r_w;
    logic [31:0]        r_meas;
    logic               r_last;
    logic [31:0]        r_ma;
    logic [23:0]        r_mb;
    logic [55:0]        r_prod;
    logic [55:0]        r_lo;
    logic [47:0]        r_rat;
    logic [39:0]        r_sen;
    logic [79:0]        r_dvd;
    logic [47:0]        r_dvs;
    logic [48:0]        r_rem;
    logic [31:0]        r_quo;
    logic               r_big;
    logic [6:0]         r_dcnt;
    logic               r_ap;
    t_out               r_pend;
    t_out               r_out;
    logic               r_ovalid;

    // memory ports
    logic               img_we, rat_we, sen_we, buf_we;
    logic [31:0]        img_wdata, img_rdata;
    logic [47:0]        rat_wdata, rat_rdata;
    logic [39:0]        sen_wdata, sen_rdata;
    logic [35:0]        buf_rdata;
    logic [VOX_AW-1:0]  img_raddr;

    logic               accept, in_range, ray_full;
    logic [48:0]        sum49, rat49, dtry;
    logic [40:0]        sen41;
    logic [47:0]        sum_sat, rat_sat;
    logic [39:0]        sen_sat;
    logic               dge;
    logic [79:0]        ap_dvd;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign in_range    = 32'(i_in.voxel_index) < VOXELS;
    assign ray_full    = 32'(r_cnt) >= MAX_SEGMENTS;
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    assign sum49   = {1'b0, r_sum} + 49'(r_prod[55:16]);
    assign sum_sat = sum49[48] ? '1 : sum49[47:0];
    assign rat49   = {1'b0, rat_rdata} + 49'(r_prod[55:16]);
    assign rat_sat = rat49[48] ? '1 : rat49[47:0];
    assign sen41   = {1'b0, sen_rdata} + 41'(r_w);
    assign sen_sat = sen41[40] ? '1 : sen41[39:0];
    assign dtry    = {r_rem[47:0], r_dvd[79]};
    assign dge     = dtry >= {1'b0, r_dvs};
    assign ap_dvd  = 80'(r_lo) + {r_prod, 24'b0};
    assign img_raddr = (r_state == S_IDLE) ? VOX_AW'(i_in.voxel_index) : r_addr;

    always_comb begin
        img_we    = 1'b0;
        img_wdata = r_init;
        rat_we    = 1'b0;
        rat_wdata = '0;
        sen_we    = 1'b0;
        sen_wdata = '0;
        buf_we    = accept && (i_in.action == ACT_SEGMENT) && in_range && !ray_full;
        unique case (r_state)
            S_CLR: begin
                img_we    = 1'b1;
                img_wdata = INIT_RESET;
                rat_we    = 1'b1;
                sen_we    = 1'b1;
            end
            S_RL:    img_we = 1'b1;
            S_BP_W: begin
                rat_we    = 1'b1;
                rat_wdata = rat_sat;
                sen_we    = 1'b1;
                sen_wdata = sen_sat;
            end
            S_AP_CK: begin
                rat_we = (sen_rdata == '0);
                sen_we = (sen_rdata == '0);
            end
            S_AP_WR: begin
                img_we    = 1'b1;
                img_wdata = r_big ? '1 : r_quo;
                rat_we    = 1'b1;
                sen_we    = 1'b1;
            end
            default: ;
        endcase
    end

    mpu_ram #(.WIDTH(32), .DEPTH(VOXELS)) u_image (
        .i_clk(i_clk), .i_we(img_we), .i_waddr(r_addr), .i_wdata(img_wdata),
        .i_raddr(img_raddr), .o_rdata(img_rdata)
    );
    mpu_ram #(.WIDTH(48), .DEPTH(VOXELS)) u_ratio (
        .i_clk(i_clk), .i_we(rat_we), .i_waddr(r_addr), .i_wdata(rat_wdata),
        .i_raddr(r_addr), .o_rdata(rat_rdata)
    );
    mpu_ram #(.WIDTH(40), .DEPTH(VOXELS)) u_sens (
        .i_clk(i_clk), .i_we(sen_we), .i_waddr(r_addr), .i_wdata(sen_wdata),
        .i_raddr(r_addr), .o_rdata(sen_rdata)
    );
    mpu_ram #(.WIDTH(36), .DEPTH(MAX_SEGMENTS)) u_segbuf (
        .i_clk(i_clk), .i_we(buf_we), .i_waddr(r_cnt[SEG_AW-1:0]),
        .i_wdata({i_in.voxel_index, i_in.segment_weight}),
        .i_raddr(r_bptr[SEG_AW-1:0]), .o_rdata(buf_rdata)
    );

    // shared multiplier, operands registered the cycle before
    always_ff @(posedge i_clk) begin
        r_prod <= r_ma * r_mb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_init   <= INIT_RESET;
            r_cnt    <= '0;
            r_sum    <= '0;
            r_addr   <= '0;
            r_ovalid <= 1'b0;
            r_bptr   <= '0;
            r_ap     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_init <= i_cfg_data;
            end
            if (r_state == S_OUT && (!r_ovalid || i_out_ready)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == VOX_AW'(VOXELS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_w    <= i_in.segment_weight;
                        r_meas <= i_in.measured_projection;
                        r_last <= i_in.last_segment;
                        r_pend <= '0;
                        unique case (i_in.action)
                            ACT_SEGMENT: begin
                                if (in_range && !ray_full) begin
                                    r_cnt   <= r_cnt + 1'b1;
                                    r_state <= S_SEG_RD;
                                end else begin
                                    if (in_range) begin
                                        r_cnt <= CNT_W'(MAX_SEGMENTS + 1);
                                    end
                                    r_state <= i_in.last_segment ? S_RAY_END : S_IDLE;
                                end
                            end
                            ACT_APPLY: begin
                                r_addr  <= '0;
                                r_state <= S_AP_RD;
                            end
                            ACT_READ: begin
                                r_addr  <= VOX_AW'(i_in.voxel_index);
                                r_ap    <= in_range;
                                r_state <= S_RD_WAIT;
                            end
                            ACT_RELOAD: begin
                                r_addr  <= '0;
                                r_state <= S_RL;
                            end
                        endcase
                    end
                end
                S_SEG_RD: begin
                    r_ma    <= img_rdata;
                    r_mb    <= r_w;
                    r_state <= S_SEG_MUL;
                end
                S_SEG_MUL: r_state <= S_SEG_ACC;
                S_SEG_ACC: begin
                    r_sum   <= sum_sat;
                    r_state <= r_last ? S_RAY_END : S_IDLE;
                end
                S_RAY_END: begin
                    if (32'(r_cnt) > MAX_SEGMENTS) begin
                        r_pend.ray_overflow <= 1'b1;
                        r_cnt   <= '0;
                        r_sum   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_dvd   <= {32'b0, r_meas, 16'b0};
                        r_dvs   <= (r_sum < ONE_Q16) ? ONE_Q16 : r_sum;
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_big   <= 1'b0;
                        r_dcnt  <= 7'd79;
                        r_ap    <= 1'b0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= dge ? dtry - {1'b0, r_dvs} : dtry;
                    r_dvd  <= {r_dvd[78:0], 1'b0};
                    r_quo  <= {r_quo[30:0], dge};
                    if (dge && r_dcnt >= 7'd32) begin
                        r_big <= 1'b1;
                    end
                    r_dcnt <= r_dcnt - 1'b1;
                    if (r_dcnt == '0) begin
                        if (r_ap) begin
                            r_state <= S_AP_WR;
                        end else if (r_cnt == '0) begin
                            r_pend.forward_sum <= r_sum;
                            r_sum   <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_bptr  <= '0;
                            r_state <= S_BP_RB;
                        end
                    end
                end
                S_BP_RB: r_state <= S_BP_E;
                S_BP_E: begin
                    r_addr  <= VOX_AW'(buf_rdata[35:24]);
                    r_w     <= buf_rdata[23:0];
                    r_ma    <= r_quo;
                    r_mb    <= buf_rdata[23:0];
                    r_state <= S_BP_M;
                end
                S_BP_M: r_state <= S_BP_W;
                S_BP_W: begin
                    r_bptr <= r_bptr + 1'b1;
                    if (r_bptr + 1'b1 == r_cnt) begin
                        r_pend.forward_sum <= r_sum;
                        r_sum   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_BP_RB;
                    end
                end
                S_AP_RD: r_state <= S_AP_CK;
                S_AP_CK: begin
                    r_rat <= rat_rdata;
                    r_sen <= sen_rdata;
                    r_ma  <= img_rdata;
                    r_mb  <= rat_rdata[23:0];
                    if (sen_rdata == '0) begin
                        r_addr <= r_addr + 1'b1;
                        if (r_addr == VOX_AW'(VOXELS - 1)) begin
                            r_pend.done_res <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_AP_RD;
                        end
                    end else begin
                        r_state <= S_AP_M1;
                    end
                end
                S_AP_M1: begin
                    r_mb    <= r_rat[47:24];
                    r_state <= S_AP_M2;
                end
                S_AP_M2: begin
                    r_lo    <= r_prod;
                    r_state <= S_AP_M3;
                end
                S_AP_M3: begin
                    r_dvd   <= ap_dvd;
                    r_dvs   <= {8'b0, r_sen};
                    r_rem   <= '0;
                    r_quo   <= '0;
                    r_big   <= 1'b0;
                    r_dcnt  <= 7'd79;
                    r_ap    <= 1'b1;
                    r_state <= S_DIV;
                end
                S_AP_WR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == VOX_AW'(VOXELS - 1)) begin
                        r_pend.done_res <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_AP_RD;
                    end
                end
                S_RD_WAIT: begin
                    r_pend.voxel_value <= r_ap ? img_rdata : '0;
                    r_state <= S_OUT;
                end
                S_RL: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == VOX_AW'(VOXELS - 1)) begin
                        r_pend.done_res <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || i_out_ready) begin
                        r_out    <= r_pend;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= MAX_SEGMENTS + 1)
        else $error("segment count out of range");
    a_clr_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !o_in_ready)
        else $error("input accepted during clearing pass");
    a_ovf_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.ray_overflow) |-> (o_out.forward_sum == '0))
        else $error("overflowed ray reports a forward sum");
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && (!r_ovalid || i_out_ready)) |=> (o_out_valid && o_in_ready))
        else $error("result not presented after completion");
endmodule
